// ===== hdl/pmic_rb_pkg.sv =====
// Shared types, register addresses and constants of the PMIC register block.
`default_nettype none
package pmic_rb_pkg;

	localparam int OP_W       = 2;
	localparam int ADDR_W     = 8;
	localparam int DATA_W     = 8;
	localparam int SAMPLE_W   = 12;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	localparam logic [ADDR_W-1:0] ADDR_POWER_STATUS = 8'h00;
	localparam logic [ADDR_W-1:0] ADDR_OUTPUT_CTRL  = 8'h12;
	localparam logic [ADDR_W-1:0] ADDR_DCDC2        = 8'h23;
	localparam logic [ADDR_W-1:0] ADDR_DCDC1        = 8'h26;
	localparam logic [ADDR_W-1:0] ADDR_DCDC3        = 8'h27;
	localparam logic [ADDR_W-1:0] ADDR_LDO_PAIR     = 8'h28;
	localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN     = 8'h32;
	localparam logic [ADDR_W-1:0] ADDR_MISC1        = 8'h33;
	localparam logic [ADDR_W-1:0] ADDR_MISC2        = 8'h35;
	localparam logic [ADDR_W-1:0] ADDR_MISC3        = 8'h36;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE   = 8'h42;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_STATUS   = 8'h46;
	localparam logic [ADDR_W-1:0] ADDR_BATT_HIGH    = 8'h78;
	localparam logic [ADDR_W-1:0] ADDR_BATT_LOW     = 8'h79;
	localparam logic [ADDR_W-1:0] ADDR_MISC4        = 8'h82;
	localparam logic [ADDR_W-1:0] ADDR_GPIO_FUNC    = 8'h90;
	localparam logic [ADDR_W-1:0] ADDR_GPIO_VOLT    = 8'h91;

	localparam logic [DATA_W-1:0] STATUS_VBUS      = 8'h20;
	localparam logic [6:0]        RAIL_ENABLE_BITS = 7'h5F;
	localparam logic [2:0]        GPIO_FUNC_LDO    = 3'h2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] battery_sample;
		logic                long_key_event;
		logic                short_key_event;
		logic                vbus_in;
		logic [DATA_W-1:0]   wdata;
		logic [ADDR_W-1:0]   addr;
		logic [OP_W-1:0]     op;
	} item_t;

	typedef struct packed {
		logic        irq_out;
		logic        power_off_req;
		logic        ldoio_on;
		logic [3:0]  ldoio_code;
		logic [3:0]  ldo3_code;
		logic [3:0]  ldo2_code;
		logic [6:0]  dcdc3_code;
		logic [5:0]  dcdc2_code;
		logic [6:0]  dcdc1_code;
		logic [6:0]  rail_enables;
		logic [7:0]  rdata;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/pmic_rb_regs.sv =====
// Register storage, access decode, key-event latching and result decode.
`default_nettype none
module pmic_rb_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire pmic_rb_pkg::item_t item,
	output pmic_rb_pkg::res_t       res
);
	import pmic_rb_pkg::*;

	logic [7:0]  out_ctrl_q, dcdc1_q, dcdc2_q, dcdc3_q, ldo_pair_q;
	logic [7:0]  shutdown_q, misc1_q, misc2_q, misc3_q, misc4_q;
	logic [7:0]  irq_en_q, gpio_func_q, gpio_volt_q;
	logic [1:0]  irq_stat_q;
	logic [11:0] batt_q;

	logic [7:0]  out_ctrl_d, dcdc1_d, dcdc2_d, dcdc3_d, ldo_pair_d;
	logic [7:0]  shutdown_d, misc1_d, misc2_d, misc3_d, misc4_d;
	logic [7:0]  irq_en_d, gpio_func_d, gpio_volt_d;
	logic [1:0]  irq_stat_clr, irq_stat_d;
	logic [7:0]  rd_byte;

	always_comb begin
		out_ctrl_d   = out_ctrl_q;
		dcdc1_d      = dcdc1_q;
		dcdc2_d      = dcdc2_q;
		dcdc3_d      = dcdc3_q;
		ldo_pair_d   = ldo_pair_q;
		shutdown_d   = shutdown_q;
		misc1_d      = misc1_q;
		misc2_d      = misc2_q;
		misc3_d      = misc3_q;
		misc4_d      = misc4_q;
		irq_en_d     = irq_en_q;
		gpio_func_d  = gpio_func_q;
		gpio_volt_d  = gpio_volt_q;
		irq_stat_clr = irq_stat_q;
		if (item.op == OP_WRITE) begin
			unique case (item.addr)
				ADDR_OUTPUT_CTRL: out_ctrl_d   = item.wdata;
				ADDR_DCDC1:       dcdc1_d      = item.wdata;
				ADDR_DCDC2:       dcdc2_d      = item.wdata;
				ADDR_DCDC3:       dcdc3_d      = item.wdata;
				ADDR_LDO_PAIR:    ldo_pair_d   = item.wdata;
				ADDR_SHUTDOWN:    shutdown_d   = item.wdata;
				ADDR_MISC1:       misc1_d      = item.wdata;
				ADDR_MISC2:       misc2_d      = item.wdata;
				ADDR_MISC3:       misc3_d      = item.wdata;
				ADDR_MISC4:       misc4_d      = item.wdata;
				ADDR_IRQ_ENABLE:  irq_en_d     = item.wdata;
				ADDR_GPIO_FUNC:   gpio_func_d  = item.wdata;
				ADDR_GPIO_VOLT:   gpio_volt_d  = item.wdata;
				ADDR_IRQ_STATUS:  irq_stat_clr = irq_stat_q & ~item.wdata[1:0];
				default: ;
			endcase
		end
		// A new event wins over a clear in the same transaction.
		irq_stat_d = irq_stat_clr |
			({item.short_key_event, item.long_key_event} & irq_en_q[1:0]);
	end

	always_comb begin
		rd_byte = '0;
		if (item.op == OP_READ) begin
			unique case (item.addr)
				ADDR_POWER_STATUS: rd_byte = item.vbus_in ? STATUS_VBUS : 8'h00;
				ADDR_OUTPUT_CTRL:  rd_byte = out_ctrl_q;
				ADDR_DCDC1:        rd_byte = dcdc1_q;
				ADDR_DCDC2:        rd_byte = dcdc2_q;
				ADDR_DCDC3:        rd_byte = dcdc3_q;
				ADDR_LDO_PAIR:     rd_byte = ldo_pair_q;
				ADDR_SHUTDOWN:     rd_byte = shutdown_q;
				ADDR_MISC1:        rd_byte = misc1_q;
				ADDR_MISC2:        rd_byte = misc2_q;
				ADDR_MISC3:        rd_byte = misc3_q;
				ADDR_MISC4:        rd_byte = misc4_q;
				ADDR_IRQ_ENABLE:   rd_byte = irq_en_q;
				ADDR_GPIO_FUNC:    rd_byte = gpio_func_q;
				ADDR_GPIO_VOLT:    rd_byte = gpio_volt_q;
				ADDR_IRQ_STATUS:   rd_byte = {6'b0, irq_stat_q};
				ADDR_BATT_HIGH:    rd_byte = batt_q[11:4];
				ADDR_BATT_LOW:     rd_byte = {4'b0, batt_q[3:0]};
				default:           rd_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctrl_q  <= '0;
			dcdc1_q     <= '0;
			dcdc2_q     <= '0;
			dcdc3_q     <= '0;
			ldo_pair_q  <= '0;
			shutdown_q  <= '0;
			misc1_q     <= '0;
			misc2_q     <= '0;
			misc3_q     <= '0;
			misc4_q     <= '0;
			irq_en_q    <= '0;
			gpio_func_q <= '0;
			gpio_volt_q <= '0;
			irq_stat_q  <= '0;
			batt_q      <= '0;
		end else if (adv) begin
			out_ctrl_q  <= out_ctrl_d;
			dcdc1_q     <= dcdc1_d;
			dcdc2_q     <= dcdc2_d;
			dcdc3_q     <= dcdc3_d;
			ldo_pair_q  <= ldo_pair_d;
			shutdown_q  <= shutdown_d;
			misc1_q     <= misc1_d;
			misc2_q     <= misc2_d;
			misc3_q     <= misc3_d;
			misc4_q     <= misc4_d;
			irq_en_q    <= irq_en_d;
			gpio_func_q <= gpio_func_d;
			gpio_volt_q <= gpio_volt_d;
			irq_stat_q  <= irq_stat_d;
			batt_q      <= item.battery_sample;
		end
	end

	always_comb begin
		res.rdata         = rd_byte;
		res.rail_enables  = out_ctrl_d[6:0] & RAIL_ENABLE_BITS;
		res.dcdc1_code    = dcdc1_d[6:0];
		res.dcdc2_code    = dcdc2_d[5:0];
		res.dcdc3_code    = dcdc3_d[6:0];
		res.ldo2_code     = ldo_pair_d[7:4];
		res.ldo3_code     = ldo_pair_d[3:0];
		res.ldoio_code    = gpio_volt_d[7:4];
		res.ldoio_on      = (gpio_func_d[2:0] == GPIO_FUNC_LDO);
		res.power_off_req = shutdown_d[7];
		res.irq_out       = |irq_stat_d;
	end

endmodule
`default_nettype wire

// ===== hdl/pmic_register_block_core.sv =====
// Top level of the PMIC register block: input stage, register file and result stage.
// One transaction carries an optional register read or write plus sampled pins and
// yields exactly one result transaction. The block takes a new transaction every clock
// cycle unless a result stalls at the output; each one is held in the input register,
// where the register file decodes it and updates its state, and then waits in the result
// register until taken. Reads see register contents from before the transaction, except
// power status at 0x00, which shows the VBUS pin of the same transaction; all other
// result fields show the state after it.
`default_nettype none
module pmic_register_block_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// addr, wdata, vbus_in, short_key_event, long_key_event, battery_sample, zero pad
	input  wire logic [pmic_rb_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  wire logic [pmic_rb_pkg::OP_W-1:0]        s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// rdata, rail_enables, dcdc1_code, dcdc2_code, dcdc3_code, ldo2_code, ldo3_code,
	// ldoio_code, ldoio_on, power_off_req, irq_out, zero pad
	output logic [pmic_rb_pkg::OUT_DATA_W-1:0]       m_tdata
);
	import pmic_rb_pkg::*;

	item_t item_in, item_s1;
	res_t  res, res_s2;
	logic  valid_s1, valid_s2, adv;

	assign item_in.op              = s_tuser;
	assign item_in.addr            = s_tdata[7:0];
	assign item_in.wdata           = s_tdata[15:8];
	assign item_in.vbus_in         = s_tdata[16];
	assign item_in.short_key_event = s_tdata[17];
	assign item_in.long_key_event  = s_tdata[18];
	assign item_in.battery_sample  = s_tdata[30:19];

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	pmic_rb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, res_s2.irq_out, res_s2.power_off_req, res_s2.ldoio_on,
		res_s2.ldoio_code, res_s2.ldo3_code, res_s2.ldo2_code, res_s2.dcdc3_code,
		res_s2.dcdc2_code, res_s2.dcdc1_code, res_s2.rail_enables, res_s2.rdata};

endmodule
`default_nettype wire

// ===== hdl/pmic_rb_checker.sv =====
// Port-level checker for the PMIC register block, bound to the top level.
`default_nettype none
module pmic_rb_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [pmic_rb_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import pmic_rb_pkg::*;

	// A held result must not change while the sink stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input side only stalls when a result is waiting at the output.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with an empty output");

	// Rail enable bit five is masked off.
	a_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[13])
		else $error("masked rail enable bit set");

	// Padding above the last result field is zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:50] == '0))
		else $error("result padding not zero");

endmodule

bind pmic_register_block_core pmic_rb_checker u_pmic_rb_checker (.*);
`default_nettype wire
